// ===== src/etsm_pkg.sv =====
package etsm_pkg;

  localparam int unsigned TASK_W    = 3;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned RUN_W     = 32;
  localparam int unsigned JIT_W     = 48;
  localparam int unsigned DIV_W     = 48;
  localparam int unsigned DIV_CNT_W = 6;

  localparam logic [JIT_W-1:0] JIT_MAX = {1'b0, {(JIT_W-1){1'b1}}};
  localparam logic [JIT_W-1:0] JIT_MIN = {1'b1, {(JIT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_MDIV,
    ST_JDIV
  } state_e;

  typedef struct packed {
    logic [RUN_W-1:0] count;
    logic [RUN_W-1:0] worst;
    logic [RUN_W-1:0] mean;
    logic [JIT_W-1:0] jitter;
  } stats_t;

  typedef struct packed {
    logic start;
    logic wide;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } div_rsp_t;

endpackage

// ===== src/etsm_div.sv =====
module etsm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  etsm_pkg::div_req_t        req_i,
  input  logic [etsm_pkg::DIV_W-1:0] dividend_i,
  input  logic [etsm_pkg::RUN_W-1:0] divisor_i,
  output etsm_pkg::div_rsp_t        rsp_o,
  output logic [etsm_pkg::DIV_W-1:0] quot_o
);
  import etsm_pkg::*;

  logic                 run_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     num_q;
  logic [DIV_W-1:0]     quot_q;
  logic [RUN_W-1:0]     rem_q;
  logic [RUN_W-1:0]     den_q;

  logic [RUN_W:0]       trial;
  logic [RUN_W:0]       diff;
  logic                 ge;
  logic [RUN_W-1:0]     rem_d;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_q, num_q[DIV_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? diff[RUN_W-1:0] : trial[RUN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= req_i.wide ? DIV_CNT_W'(DIV_W) : DIV_CNT_W'(RUN_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q  <= req_i.wide ? dividend_i
                           : {dividend_i[RUN_W-1:0], {(DIV_W-RUN_W){1'b0}}};
      den_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (run_q) begin
      num_q  <= {num_q[DIV_W-2:0], 1'b0};
      rem_q  <= rem_d;
      quot_q <= {quot_q[DIV_W-2:0], ge};
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.rem_nz = |rem_q;
  assign quot_o       = quot_q;

endmodule

// ===== src/etsm_store.sv =====
module etsm_store #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned IDX_W = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [IDX_W-1:0]     idx_i,
  input  logic                 we_i,
  input  etsm_pkg::stats_t     wdata_i,
  output etsm_pkg::stats_t     rdata_o
);
  import etsm_pkg::*;

  stats_t entry_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        entry_q[i] <= '0;
      end
    end else if (we_i) begin
      entry_q[idx_i] <= wdata_i;
    end
  end

  assign rdata_o = entry_q[idx_i];

endmodule

// ===== src/execution_time_statistics.sv =====
// Per-task execution-time monitor. Raise start with a task index and its start and
// stop timestamps while busy is low; the request is taken at that edge. One result
// follows per request, shown for a single cycle with valid_o high; it cannot be held
// off, so capture it in that cycle. From acceptance to strobe, a request in range
// passes a calculation state and then a serial divider producing one quotient bit
// per cycle, a 32-bit quotient for the new mean and then a 48-bit one for the
// mean jitter. A task index at or above NUM_TASKS leaves the statistics untouched
// and reports straight from the calculation state. busy is low again in the strobe
// cycle, so the next request may be taken then. All statistics are zero after reset.
module execution_time_statistics #(
  parameter int unsigned NUM_TASKS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [etsm_pkg::TASK_W-1:0]       task_index_i,
  input  logic [etsm_pkg::TIME_W-1:0]       start_time_i,
  input  logic [etsm_pkg::TIME_W-1:0]       stop_time_i,
  output logic                              valid_o,
  output logic [etsm_pkg::TASK_W-1:0]       task_id_o,
  output logic [etsm_pkg::RUN_W-1:0]        run_time_o,
  output logic [etsm_pkg::RUN_W-1:0]        runs_seen_o,
  output logic [etsm_pkg::RUN_W-1:0]        worst_run_o,
  output logic [etsm_pkg::RUN_W-1:0]        mean_run_o,
  output logic signed [etsm_pkg::JIT_W-1:0] jitter_total_o,
  output logic signed [etsm_pkg::JIT_W-1:0] jitter_mean_o
);
  import etsm_pkg::*;

  // only indices reachable by the task field need storage
  localparam int unsigned ADDR_SPAN   = 2 ** TASK_W;
  localparam int unsigned STORE_DEPTH = (NUM_TASKS < ADDR_SPAN) ? NUM_TASKS : ADDR_SPAN;
  localparam int unsigned IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  state_e state_q, state_d;
  logic   valid_q, valid_d;

  logic [TASK_W-1:0] idx_q;
  logic [RUN_W-1:0]  d_q;
  logic [RUN_W-1:0]  n_q;
  logic [RUN_W-1:0]  worst_q;
  logic [RUN_W-1:0]  mean_q;
  logic              mneg_q;
  logic [JIT_W-1:0]  jit_q;
  logic [JIT_W-1:0]  jmean_q;

  logic              accept;
  logic [TIME_W-1:0] dur;
  logic [RUN_W-1:0]  d_in;
  logic              in_range;

  stats_t            rd;
  stats_t            wr;
  logic              store_we;

  logic [RUN_W-1:0]  n_calc;
  logic [RUN_W-1:0]  worst_calc;
  logic              mneg_calc;
  logic [RUN_W-1:0]  mdiff_mag;
  logic [RUN_W:0]    diff_s;
  logic [JIT_W:0]    jsum;
  logic [JIT_W-1:0]  jsat;
  logic [JIT_W-1:0]  jit_calc;
  logic [JIT_W-1:0]  jmag;
  logic [RUN_W-1:0]  mean_new;

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [DIV_W-1:0]  div_num;
  logic [RUN_W-1:0]  div_den;
  logic [DIV_W-1:0]  quot;

  assign accept = start && !busy;

  always_comb begin
    dur  = (stop_time_i > start_time_i) ? (stop_time_i - start_time_i) : '0;
    d_in = (|dur[TIME_W-1:RUN_W]) ? '1 : dur[RUN_W-1:0];
  end

  assign in_range = 32'(idx_q) < NUM_TASKS;

  // statistics update for the request in hand
  always_comb begin
    n_calc     = (rd.count == '1) ? rd.count : rd.count + 1'b1;
    worst_calc = (d_q > rd.worst) ? d_q : rd.worst;
    mneg_calc  = rd.mean > d_q;
    mdiff_mag  = mneg_calc ? rd.mean - d_q : d_q - rd.mean;
    diff_s     = {1'b0, d_q} - {1'b0, rd.mean};
    jsum       = {rd.jitter[JIT_W-1], rd.jitter}
               + {{(JIT_W-RUN_W){diff_s[RUN_W]}}, diff_s};
    if (jsum[JIT_W] != jsum[JIT_W-1]) begin
      jsat = jsum[JIT_W] ? JIT_MIN : JIT_MAX;
    end else begin
      jsat = jsum[JIT_W-1:0];
    end
    jit_calc = (n_calc > RUN_W'(1)) ? jsat : rd.jitter;
    jmag     = jit_q[JIT_W-1] ? (~jit_q + 1'b1) : jit_q;
    // mean*(n-1)+d over n, as old mean plus or minus the rounded step
    mean_new = mneg_q ? mean_q - quot[RUN_W-1:0] - RUN_W'(div_rsp.rem_nz)
                      : mean_q + quot[RUN_W-1:0];
  end

  always_comb begin
    div_num = (state_q == ST_CALC) ? {{(DIV_W-RUN_W){1'b0}}, mdiff_mag} : jmag;
    div_den = (state_q == ST_CALC) ? n_calc : n_q;
  end

  assign wr.count  = n_q;
  assign wr.worst  = worst_q;
  assign wr.mean   = mean_new;
  assign wr.jitter = jit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    valid_d       = 1'b0;
    store_we      = 1'b0;
    div_req.start = 1'b0;
    div_req.wide  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (in_range) begin
          div_req.start = 1'b1;
          state_d       = ST_MDIV;
        end else begin
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_MDIV: begin
        if (div_rsp.done) begin
          store_we      = 1'b1;
          div_req.start = 1'b1;
          div_req.wide  = 1'b1;
          state_d       = ST_JDIV;
        end
      end
      ST_JDIV: begin
        if (div_rsp.done) begin
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q <= task_index_i;
      d_q   <= d_in;
    end
    if (state_q == ST_CALC) begin
      if (in_range) begin
        n_q     <= n_calc;
        worst_q <= worst_calc;
        mean_q  <= rd.mean;
        mneg_q  <= mneg_calc;
        jit_q   <= jit_calc;
      end else begin
        n_q     <= '0;
        worst_q <= '0;
        mean_q  <= '0;
        mneg_q  <= 1'b0;
        jit_q   <= '0;
        jmean_q <= '0;
      end
    end
    if (state_q == ST_MDIV && div_rsp.done) begin
      mean_q <= mean_new;
    end
    if (state_q == ST_JDIV && div_rsp.done) begin
      jmean_q <= jit_q[JIT_W-1] ? (~quot + 1'b1) : quot;
    end
  end

  etsm_store #(
    .DEPTH (STORE_DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .idx_i   (idx_q[IDX_W-1:0]),
    .we_i    (store_we),
    .wdata_i (wr),
    .rdata_o (rd)
  );

  etsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .rsp_o      (div_rsp),
    .quot_o     (quot)
  );

  assign busy           = state_q != ST_IDLE;
  assign valid_o        = valid_q;
  assign task_id_o      = idx_q;
  assign run_time_o     = d_q;
  assign runs_seen_o    = n_q;
  assign worst_run_o    = worst_q;
  assign mean_run_o     = mean_q;
  assign jitter_total_o = $signed(jit_q);
  assign jitter_mean_o  = $signed(jmean_q);

  // strobe is a single-cycle pulse
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after an accepted request");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && runs_seen_o == '0) |->
      (worst_run_o == '0 && mean_run_o == '0 && jitter_total_o == '0
       && jitter_mean_o == '0))
    else $error("out-of-range result carries statistics");

  a_worst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && runs_seen_o != '0) |-> (worst_run_o >= run_time_o
                                        && worst_run_o >= mean_run_o))
    else $error("worst duration below current or mean duration");

endmodule
